FILE: design/olkd_pkg.sv
// Package for the ordered list unit: payload structs, operation and status codes,
// and default sizes. Used by every module in the design folder; depends on nothing.
package olkd_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_VALUE_BITS = 32;

   // Operation codes carried in the request kind field.
   localparam logic [1:0] KIND_INSERT_FRONT = 2'd0;
   localparam logic [1:0] KIND_DELETE_KEY   = 2'd1;
   localparam logic [1:0] KIND_DELETE_FRONT = 2'd2;
   localparam logic [1:0] KIND_DELETE_BACK  = 2'd3;

   // Status codes reported with every result.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // One request transfer.
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   // One result transfer.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         entry_count;
   } rsp_type;

endpackage

FILE: design/ordered_list_with_key_delete_unit.sv
// Ordered list with key delete. Each operation other than a key delete reads the front
// and then the back entry (the back read is skipped when the list is empty afterward)
// before its registered result strobe. A key delete adds a key scan and a gap close
// before these reads, both through the single memory read port. A new start is taken once
// busy falls, in the cycle of the strobe. Synchronous active-high reset empties the list;
// results cannot be stalled.
module ordered_list_with_key_delete_unit
   import olkd_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   logic                  done;
   rsp_type               result;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_payload_ff;

   olkd_store #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   olkd_seq #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .busy        (busy),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .done        (done),
      .result      (result)
   );

   // Result register: one strobe cycle per transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: design/olkd_store.sv
// Entry memory of the ordered list: one write port and one registered read port.
// Uses olkd_pkg only for its house defaults.
module olkd_store
   import olkd_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] entry_mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered and available in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/olkd_seq.sv
// Sequencer of the ordered list: circular head pointer, entry count, one shared address
// unit that drives the key scan, the gap close and the final reads, and a key comparator.
// Depends on olkd_pkg for codes and payload types.
module olkd_seq
   import olkd_pkg::*;
#(
   parameter int DEPTH      = DEFAULT_DEPTH,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  req_type               req_payload,
   output logic                  busy,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [VALUE_BITS-1:0] wr_data,
   output logic [AW-1:0]         rd_addr,
   input  logic [VALUE_BITS-1:0] rd_data,
   output logic                  done,
   output rsp_type               result
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_FRONT = 3'd3;
   localparam logic [2:0] S_BACK  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         rd_phys_ff, rd_phys_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0] front_ff, front_in;
   logic [1:0]            status_ff, status_in;

   logic [CW-1:0]         phys_off;
   logic [SW-1:0]         phys_sum;
   logic [AW-1:0]         phys;
   logic [AW-1:0]         head_dec;
   logic [AW-1:0]         head_inc;
   logic [VALUE_BITS-1:0] req_v;
   logic [63:0]           req_wide;
   logic [63:0]           front_wide;
   logic [63:0]           back_wide;
   logic                  issue;

   // Step back one place around the circular store.
   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
      wrap_dec = (a == '0) ? LAST_A : AW'(a - 1'b1);
   endfunction

   // Request value reduced to the stored width.
   assign req_wide = {32'b0, req_payload.value};
   assign req_v    = req_wide[VALUE_BITS-1:0];

   // Shared address unit: list offset to store address, one wrap at most.
   assign phys_sum = SW'(head_ff) + SW'(phys_off);
   assign phys     = (phys_sum >= SW'(DEPTH)) ? AW'(phys_sum - SW'(DEPTH)) : AW'(phys_sum);
   assign rd_addr  = phys;

   assign head_dec = wrap_dec(head_ff);
   assign head_inc = (head_ff == LAST_A) ? '0 : AW'(head_ff + 1'b1);
   assign issue    = (idx_ff < count_ff);
   assign busy     = (state_ff != S_IDLE);

   // Next-state and datapath control.
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      rd_phys_in = rd_phys_ff;
      key_in     = key_ff;
      front_in   = front_ff;
      status_in  = status_ff;
      phys_off   = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = head_dec;
      wr_data    = req_v;
      done       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = STATUS_DONE;
               state_in  = S_FRONT;
               if (req_payload.kind == KIND_INSERT_FRONT) begin
                  if (count_ff == DEPTH_C) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     head_in  = head_dec;
                     count_in = CW'(count_ff + 1'b1);
                  end
               end else if (count_ff == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  case (req_payload.kind)
                     KIND_DELETE_KEY: begin
                        key_in   = req_v;
                        idx_in   = '0;
                        pend_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                     KIND_DELETE_FRONT: begin
                        head_in  = head_inc;
                        count_in = CW'(count_ff - 1'b1);
                     end
                     default: begin
                        count_in = CW'(count_ff - 1'b1);
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            // Read one entry a cycle, compare the one read the cycle before.
            if (pend_ff && (rd_data == key_ff)) begin
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else if (pend_ff && (idx_ff == count_ff)) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_FRONT;
            end else begin
               idx_in  = CW'(idx_ff + 1'b1);
               pend_in = 1'b1;
            end
         end
         S_SHIFT: begin
            // Move each later entry down one place; a write follows in the cycle after its read.
            if (issue) begin
               idx_in     = CW'(idx_ff + 1'b1);
               rd_phys_in = phys;
            end
            pend_in = issue;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wrap_dec(rd_phys_ff);
               wr_data = rd_data;
            end
            if (!issue && !pend_ff) begin
               count_in = CW'(count_ff - 1'b1);
               state_in = S_FRONT;
            end
         end
         S_FRONT: begin
            phys_off = '0;
            state_in = (count_ff == '0) ? S_RESP : S_BACK;
         end
         S_BACK: begin
            phys_off = CW'(count_ff - 1'b1);
            front_in = rd_data;
            state_in = S_RESP;
         end
         S_RESP: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result fields; an empty list reports zero at both ends.
   assign front_wide = 64'(front_ff);
   assign back_wide  = 64'(rd_data);
   always_comb begin
      result.status      = status_ff;
      result.front_value = (count_ff == '0) ? 32'sd0 : front_wide[31:0];
      result.back_value  = (count_ff == '0) ? 32'sd0 : back_wide[31:0];
      result.entry_count = 5'(count_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_phys_ff <= rd_phys_in;
      key_ff     <= key_in;
      front_ff   <= front_in;
      status_ff  <= status_in;
   end

endmodule
